@@ sv/sorted_key_value_bucket_assert.svh @@
// Assertion macros for the sorted key/value bucket.
// In synthesis builds the macros expand to nothing.
`ifndef SORTED_KEY_VALUE_BUCKET_ASSERT_SVH
`define SORTED_KEY_VALUE_BUCKET_ASSERT_SVH
`ifndef SYNTHESIS
`define SKVB_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("implication check failed");
`define SKVB_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("next-cycle check failed");
`else
`define SKVB_ASSERT_IMPL(label, clk, rst_n, a, c)
`define SKVB_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

@@ sv/skvb_pkg.sv @@
package skvb_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_BITS    = 32;
    localparam int VALUE_BITS  = 32;
    localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
    localparam int THR_BITS    = 7;

    localparam logic [THR_BITS-1:0] THRESH_RESET = THR_BITS'(32);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_FIND   = 2'd2,
        OP_NOP    = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [31:0] key;
        logic [31:0] value;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] found_value;
        logic        rejected_full;
        logic        needs_burst;
        logic [6:0]  entry_count;
    } rsp_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } entry_t;

    // Read address sources for the table memory.
    typedef enum logic [2:0] {
        RD_MID = 3'd0,
        RD_LO  = 3'd1,
        RD_DN1 = 3'd2,
        RD_DN2 = 3'd3,
        RD_UP1 = 3'd4,
        RD_UP2 = 3'd5
    } rd_sel_t;

    typedef struct packed {
        logic    load_req;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    srch_upd;
        logic    ptr_ld_count;
        logic    ptr_ld_lo;
        logic    shift_dn;
        logic    shift_up;
        logic    wr_new;
        logic    cnt_dec;
        logic    set_hit;
        logic    set_found;
        logic    set_reject;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    full;
        logic    lo_eq_hi;
        logic    lo_eq_count;
        logic    key_match;
        logic    ptr_eq_lo;
        logic    ptr_m1_eq_lo;
        logic    ptr_p1_end;
        logic    ptr_p2_end;
        logic    out_busy;
    } status_t;

endpackage

@@ sv/sorted_key_value_bucket.sv @@
// Sorted key/value bucket: a table of up to 64 key/value entries kept in
// ascending order by key, then by value, in one memory with a registered
// read port. Each request is an insert, remove, find or no-op and yields one
// response carrying the outcome, the entry count after the request and the
// needs_burst flag (count above the threshold). One request is worked on at
// a time. After a decode step, a binary search finds the lower bound (a
// no-op and an insert into a full table skip it), each halving reading the
// middle entry and then comparing it; a response step ends every request.
// An insert then shifts every entry from the insert position upward by one
// slot, one entry per cycle; a remove that hits shifts the entries above the
// match down the same way. The input is ready again in the cycle after the
// response is loaded. A finished response sits in an output register, so
// the next request can be taken while the previous response still waits to
// be read. The threshold write port is always ready and should be written
// only while the block is idle.
module sorted_key_value_bucket (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  skvb_pkg::req_t                in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output skvb_pkg::rsp_t                out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [skvb_pkg::THR_BITS-1:0] cfg_data
);
    import skvb_pkg::*;

`include "sorted_key_value_bucket_assert.svh"

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    skvb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    skvb_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    `SKVB_ASSERT_IMPL(a_count_bound, clk, rst_n, out_valid, out_data.entry_count <= 7'(TABLE_DEPTH))
    `SKVB_ASSERT_IMPL(a_reject_full, clk, rst_n, out_valid && out_data.rejected_full, !out_data.hit && out_data.entry_count == 7'(TABLE_DEPTH))
    `SKVB_ASSERT_IMPL(a_found_hit, clk, rst_n, out_valid && out_data.found_value != 32'd0, out_data.hit)
    `SKVB_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

@@ sv/skvb_ram.sv @@
module skvb_ram #(
    parameter int ADDR_BITS = 6,
    parameter int DATA_BITS = 64
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/skvb_datapath.sv @@
module skvb_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  skvb_pkg::req_t                 in_data,
    input  logic                           cfg_valid,
    input  logic [skvb_pkg::THR_BITS-1:0]  cfg_data,
    input  logic                           out_ready,
    input  skvb_pkg::cmd_t                 cmd,
    output skvb_pkg::status_t              status,
    output logic                           out_valid,
    output skvb_pkg::rsp_t                 out_data
);
    import skvb_pkg::*;

    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [THR_BITS-1:0]   thr_reg;
    logic                  out_valid_reg;
    rsp_t                  out_data_reg;

    opcode_t               op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [VALUE_BITS-1:0] sval_reg;
    logic [CNT_BITS-1:0]   lo_reg, hi_reg, mid_reg, ptr_reg;
    logic                  hit_reg, reject_reg;
    logic [VALUE_BITS-1:0] found_reg;

    logic [CNT_BITS:0]     mid_sum;
    logic [CNT_BITS-1:0]   mid;
    logic                  less;
    logic                  we;
    logic [ADDR_BITS-1:0]  waddr, raddr;
    entry_t                wdata, rdata;
    logic [CNT_BITS-1:0]   rd_idx;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CNT_BITS:1];

    // Lower-bound order: by key, then by value.
    assign less = (rdata.key < key_reg) || ((rdata.key == key_reg) && (rdata.value < sval_reg));

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_MID:  rd_idx = mid;
            RD_LO:   rd_idx = lo_reg;
            RD_DN1:  rd_idx = ptr_reg - CNT_BITS'(1);
            RD_DN2:  rd_idx = ptr_reg - CNT_BITS'(2);
            RD_UP1:  rd_idx = ptr_reg + CNT_BITS'(1);
            RD_UP2:  rd_idx = ptr_reg + CNT_BITS'(2);
            default: rd_idx = lo_reg;
        endcase
    end

    assign raddr = rd_idx[ADDR_BITS-1:0];
    assign we    = cmd.wr_new || cmd.shift_dn || cmd.shift_up;
    assign waddr = cmd.wr_new ? lo_reg[ADDR_BITS-1:0] : ptr_reg[ADDR_BITS-1:0];
    assign wdata = cmd.wr_new ? entry_t'{key: key_reg, value: val_reg} : rdata;

    skvb_ram #(
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS ($bits(entry_t))
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        count_next = count_reg;
        if (cmd.wr_new)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            thr_reg       <= THRESH_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_valid)
            begin
                thr_reg <= cfg_data;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            op_reg     <= in_data.opcode;
            key_reg    <= in_data.key[KEY_BITS-1:0];
            val_reg    <= in_data.value[VALUE_BITS-1:0];
            // Remove and find look for the first entry with the key.
            sval_reg   <= (in_data.opcode == OP_INSERT) ? in_data.value[VALUE_BITS-1:0] : '0;
            lo_reg     <= '0;
            hi_reg     <= count_reg;
            hit_reg    <= 1'b0;
            reject_reg <= 1'b0;
            found_reg  <= '0;
        end
        if (cmd.rd_en && (cmd.rd_sel == RD_MID))
        begin
            mid_reg <= mid;
        end
        if (cmd.srch_upd)
        begin
            if (less)
            begin
                lo_reg <= mid_reg + CNT_BITS'(1);
            end
            else
            begin
                hi_reg <= mid_reg;
            end
        end
        if (cmd.ptr_ld_count)
        begin
            ptr_reg <= count_reg;
        end
        else if (cmd.ptr_ld_lo)
        begin
            ptr_reg <= lo_reg;
        end
        else if (cmd.shift_dn)
        begin
            ptr_reg <= ptr_reg - CNT_BITS'(1);
        end
        else if (cmd.shift_up)
        begin
            ptr_reg <= ptr_reg + CNT_BITS'(1);
        end
        if (cmd.set_hit)
        begin
            hit_reg <= 1'b1;
        end
        if (cmd.set_found)
        begin
            found_reg <= rdata.value;
        end
        if (cmd.set_reject)
        begin
            reject_reg <= 1'b1;
        end
        if (cmd.out_load)
        begin
            out_data_reg.hit           <= hit_reg;
            out_data_reg.found_value   <= 32'(found_reg);
            out_data_reg.rejected_full <= reject_reg;
            out_data_reg.needs_burst   <= (7'(count_reg) > thr_reg);
            out_data_reg.entry_count   <= 7'(count_reg);
        end
    end

    assign status.op           = op_reg;
    assign status.full         = (count_reg == CNT_BITS'(TABLE_DEPTH));
    assign status.lo_eq_hi     = (lo_reg == hi_reg);
    assign status.lo_eq_count  = (lo_reg == count_reg);
    assign status.key_match    = (rdata.key == key_reg);
    assign status.ptr_eq_lo    = (ptr_reg == lo_reg);
    assign status.ptr_m1_eq_lo = ((ptr_reg - CNT_BITS'(1)) == lo_reg);
    assign status.ptr_p1_end   = (({1'b0, ptr_reg} + (CNT_BITS+1)'(1)) >= {1'b0, count_reg});
    assign status.ptr_p2_end   = (({1'b0, ptr_reg} + (CNT_BITS+1)'(2)) >= {1'b0, count_reg});
    assign status.out_busy     = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ sv/skvb_ctrl.sv @@
module skvb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  skvb_pkg::status_t status,
    output skvb_pkg::cmd_t    cmd
);
    import skvb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_CHK_RD,
        S_CHK,
        S_INS_PRIME,
        S_INS_SHIFT,
        S_INS_WRITE,
        S_REM_PRIME,
        S_REM_SHIFT,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_MID;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (status.op == OP_NOP)
                begin
                    state_next = S_DONE;
                end
                else if ((status.op == OP_INSERT) && status.full)
                begin
                    cmd.set_reject = 1'b1;
                    state_next     = S_DONE;
                end
                else
                begin
                    state_next = S_SRCH_RD;
                end
            end
            S_SRCH_RD:
            begin
                if (status.lo_eq_hi)
                begin
                    if (status.op == OP_INSERT)
                    begin
                        cmd.ptr_ld_count = 1'b1;
                        state_next       = S_INS_PRIME;
                    end
                    else
                    begin
                        state_next = S_CHK_RD;
                    end
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_MID;
                    state_next = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP:
            begin
                cmd.srch_upd = 1'b1;
                state_next   = S_SRCH_RD;
            end
            S_CHK_RD:
            begin
                // A lower bound at the end of the table means no match.
                if (status.lo_eq_count)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_LO;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (!status.key_match)
                begin
                    state_next = S_DONE;
                end
                else if (status.op == OP_FIND)
                begin
                    cmd.set_hit   = 1'b1;
                    cmd.set_found = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.set_hit   = 1'b1;
                    cmd.ptr_ld_lo = 1'b1;
                    state_next    = S_REM_PRIME;
                end
            end
            S_INS_PRIME:
            begin
                if (status.ptr_eq_lo)
                begin
                    state_next = S_INS_WRITE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_DN1;
                    state_next = S_INS_SHIFT;
                end
            end
            S_INS_SHIFT:
            begin
                // Write the entry read last cycle one slot up, read the next one.
                cmd.shift_dn = 1'b1;
                if (status.ptr_m1_eq_lo)
                begin
                    state_next = S_INS_WRITE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_DN2;
                end
            end
            S_INS_WRITE:
            begin
                cmd.wr_new  = 1'b1;
                cmd.set_hit = 1'b1;
                state_next  = S_DONE;
            end
            S_REM_PRIME:
            begin
                if (status.ptr_p1_end)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_UP1;
                    state_next = S_REM_SHIFT;
                end
            end
            S_REM_SHIFT:
            begin
                cmd.shift_up = 1'b1;
                if (status.ptr_p2_end)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_UP2;
                end
            end
            S_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            in_ready  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            in_ready  <= (state_next == S_IDLE);
        end
    end

endmodule
